[design/agds_pkg.sv]
package agds_pkg;

   localparam int SMP_W = 12;
   localparam int GAIN_W = 3;
   localparam int DIV_W = 3;
   localparam int CSR_IDX_W = 2;

   localparam int SAMPLES_DEF = 16;

   localparam logic [GAIN_W-1:0] GAIN_BOTTOM = 3'd0;
   localparam logic [GAIN_W-1:0] GAIN_TOP = 3'd5;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd0;
   localparam logic [DIV_W-1:0] DIV_BOTTOM = 3'd0;
   localparam logic [DIV_W-1:0] DIV_TOP = 3'd4;
   localparam logic [DIV_W-1:0] DIV_RESET = 3'd3;

   localparam logic [SMP_W-1:0] SIGNAL_LOW_RESET = 12'd500;
   localparam logic [SMP_W-1:0] SIGNAL_HIGH_RESET = 12'd3500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGNAL_LOW = 2'd0,
      CSR_SIGNAL_HIGH = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic [SMP_W-1:0] meas_avg;
      logic [SMP_W-1:0] ref_avg;
   } avg_word_type;

endpackage

[design/agds_req_if.sv]
interface agds_req_if import agds_pkg::*; ();
   logic valid;
   logic ready;
   logic [SMP_W-1:0] meas_sample;
   logic [SMP_W-1:0] ref_sample;

   modport source (output valid, output meas_sample, output ref_sample, input ready);
   modport sink (input valid, input meas_sample, input ref_sample, output ready);
endinterface

[design/agds_rsp_if.sv]
interface agds_rsp_if import agds_pkg::*; ();
   logic valid;
   logic ready;
   logic [SMP_W-1:0] avg_meas;
   logic [SMP_W-1:0] avg_ref;
   logic [GAIN_W-1:0] gain_level;
   logic [DIV_W-1:0] divider_level;
   logic range_changed;

   modport source (output valid, output avg_meas, output avg_ref, output gain_level,
                   output divider_level, output range_changed, input ready);
   modport sink (input valid, input avg_meas, input avg_ref, input gain_level,
                 input divider_level, input range_changed, output ready);
endinterface

[design/agds_csr_if.sv]
interface agds_csr_if import agds_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SMP_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[design/agds_accum.sv]
module agds_accum import agds_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic accept,
   input  logic [SMP_W-1:0] meas_sample,
   input  logic [SMP_W-1:0] ref_sample,
   output avg_word_type avg
);

   localparam int LOG_S = $clog2(SAMPLES);
   localparam int CNT_W = (SAMPLES > 1) ? LOG_S : 1;
   localparam int SUM_W = SMP_W + LOG_S;
   localparam int SHIFT = SUM_W + LOG_S;
   localparam int MUL_W = SUM_W + 1;
   localparam int PROD_W = SUM_W + MUL_W;
   localparam longint unsigned MULT = ((64'd1 << SHIFT) + SAMPLES - 1) / SAMPLES;
   localparam logic [MUL_W-1:0] MULT_K = MUL_W'(MULT);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] meas_sum_ff, meas_sum_in, ref_sum_ff, ref_sum_in;
   logic [SUM_W-1:0] meas_tot_ff, ref_tot_ff;
   logic tot_valid_ff;
   logic [PROD_W-1:0] meas_prod, ref_prod;
   avg_word_type avg_ff, avg_in;
   logic last;

   // The window mean is floor(sum / SAMPLES), taken as a multiply by a rounded-up
   // reciprocal; the extra fraction bits make it exact over the whole sum range.
   assign last = (cnt_ff == CNT_LAST);
   assign meas_sum_in = meas_sum_ff + SUM_W'(meas_sample);
   assign ref_sum_in = ref_sum_ff + SUM_W'(ref_sample);
   assign cnt_in = last ? '0 : cnt_ff + 1'b1;
   assign meas_prod = PROD_W'(meas_tot_ff) * PROD_W'(MULT_K);
   assign ref_prod = PROD_W'(ref_tot_ff) * PROD_W'(MULT_K);

   always_comb begin
      avg_in.valid = tot_valid_ff;
      avg_in.meas_avg = meas_prod[SHIFT +: SMP_W];
      avg_in.ref_avg = ref_prod[SHIFT +: SMP_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         meas_sum_ff <= '0;
         ref_sum_ff <= '0;
         tot_valid_ff <= 1'b0;
         avg_ff.valid <= 1'b0;
      end else if (advance) begin
         tot_valid_ff <= accept && last;
         avg_ff.valid <= avg_in.valid;
         avg_ff.meas_avg <= avg_in.meas_avg;
         avg_ff.ref_avg <= avg_in.ref_avg;
         if (accept) begin
            cnt_ff <= cnt_in;
            meas_sum_ff <= last ? '0 : meas_sum_in;
            ref_sum_ff <= last ? '0 : ref_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         meas_tot_ff <= meas_sum_in;
         ref_tot_ff <= ref_sum_in;
      end
   end

   assign avg = avg_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_LAST)
      else $error("sample count past the window length");

   a_sum_clear: assert property (@(posedge clock) disable iff (reset)
      advance && accept && last |=> meas_sum_ff == '0 && ref_sum_ff == '0 && tot_valid_ff)
      else $error("window close did not clear the sums");

   a_avg_follows: assert property (@(posedge clock) disable iff (reset)
      advance && tot_valid_ff |=> avg_ff.valid)
      else $error("window total lost before the average stage");

endmodule

[design/autorange_gain_divider_select_core.sv]
// Channel  Direction  Words
// req      in         meas_sample, ref_sample
// rsp      out        avg_meas, avg_ref, gain_level, divider_level, range_changed
// csr      in         index, data (0 = signal_low, 1 = signal_high)
//
// A req word is taken every clock while req.ready is high; one rsp word follows each SAMPLES req words.
// The rsp word of a window is valid once it has passed the total register, which
// loads on the edge that takes the last req word of the window, then the
// reciprocal-multiply average register, then the range result register.
// When a finished rsp word is held by rsp.ready low, the whole pipeline holds and
// req.ready drops. Reset clears the sums, count and valid bits, sets gain 0,
// divider 3 and the thresholds to 500 and 3500. csr is always ready.
module autorange_gain_divider_select_core import agds_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic clock,
   input  logic reset,
   agds_req_if.sink req,
   agds_rsp_if.source rsp,
   agds_csr_if.sink csr
);

   logic advance;
   logic accept;
   avg_word_type avg;

   logic [SMP_W-1:0] low_ff, high_ff;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic rsp_valid_ff;
   logic [SMP_W-1:0] rsp_meas_ff, rsp_ref_ff;
   logic rsp_changed_ff;
   logic load;
   logic below, above, edge_div, top_gain, bottom_gain;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && advance;
   assign req.ready = advance;
   assign csr.ready = 1'b1;
   assign load = advance && avg.valid;

   agds_accum #(
      .SAMPLES(SAMPLES)
   ) u_accum (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .accept(accept),
      .meas_sample(req.meas_sample),
      .ref_sample(req.ref_sample),
      .avg(avg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= SIGNAL_LOW_RESET;
         high_ff <= SIGNAL_HIGH_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_SIGNAL_LOW: begin
               low_ff <= csr.data;
            end
            CSR_SIGNAL_HIGH: begin
               high_ff <= csr.data;
            end
            default: begin
            end
         endcase
      end
   end

   // The below test wins over the above test when the thresholds cross.
   always_comb begin
      below = avg.meas_avg < low_ff;
      above = avg.meas_avg > high_ff;
      edge_div = div_ff inside {DIV_BOTTOM, DIV_TOP};
      top_gain = (gain_ff == GAIN_TOP);
      bottom_gain = (gain_ff == GAIN_BOTTOM);
      gain_in = gain_ff;
      div_in = div_ff;
      if (below || above) begin
         if (edge_div && top_gain) begin
            gain_in = GAIN_BOTTOM;
            div_in = (div_ff == DIV_BOTTOM) ? DIV_BOTTOM + 1'b1 : DIV_TOP - 1'b1;
         end else if (below) begin
            if (edge_div && bottom_gain) begin
               gain_in = GAIN_BOTTOM + 1'b1;
            end else if (gain_ff < GAIN_TOP) begin
               gain_in = gain_ff + 1'b1;
            end else if (div_ff < DIV_TOP) begin
               div_in = div_ff + 1'b1;
            end
         end else begin
            if (div_ff == DIV_BOTTOM && bottom_gain) begin
               div_in = div_ff;
            end else if (div_ff == DIV_TOP && bottom_gain) begin
               div_in = DIV_TOP - 1'b1;
            end else if (gain_ff inside {[GAIN_BOTTOM + 3'd1 : GAIN_TOP]}) begin
               gain_in = gain_ff - 1'b1;
            end else if (div_ff inside {[DIV_BOTTOM + 3'd1 : DIV_TOP]}) begin
               div_in = div_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         div_ff <= DIV_RESET;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= avg.valid;
         if (avg.valid) begin
            gain_ff <= gain_in;
            div_ff <= div_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_meas_ff <= avg.meas_avg;
         rsp_ref_ff <= avg.ref_avg;
         rsp_changed_ff <= (gain_in != gain_ff) || (div_in != div_ff);
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.avg_meas = rsp_meas_ff;
   assign rsp.avg_ref = rsp_ref_ff;
   assign rsp.gain_level = gain_ff;
   assign rsp.divider_level = div_ff;
   assign rsp.range_changed = rsp_changed_ff;

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_TOP && div_ff <= DIV_TOP)
      else $error("range index out of its legal codes");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_changed_ff == ((gain_ff != $past(gain_ff)) || (div_ff != $past(div_ff))))
      else $error("range_changed disagrees with the index update");

   a_range_hold: assert property (@(posedge clock) disable iff (reset)
      !load |=> gain_ff == $past(gain_ff) && div_ff == $past(div_ff))
      else $error("range moved without a finished window");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !req.ready)
      else $error("input taken while the result word is stalled");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb import agds_pkg::*; ();

   localparam int WINDOW = SAMPLES_DEF;
   localparam int ITEM_TARGET = 1950;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_PRINTED = 20;
   localparam logic [SMP_W-1:0] SMP_MAX = {SMP_W{1'b1}};
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [SMP_W-1:0] meas_sample;
      logic [SMP_W-1:0] ref_sample;
   } sample_pair_type;

   typedef struct packed {
      logic [SMP_W-1:0] avg_meas;
      logic [SMP_W-1:0] avg_ref;
      logic [GAIN_W-1:0] gain_level;
      logic [DIV_W-1:0] divider_level;
      logic range_changed;
   } range_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic [SMP_W-1:0] req_meas = '0;
   logic [SMP_W-1:0] req_ref = '0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SMP_W-1:0] csr_data = '0;

   agds_req_if req_ch ();
   agds_rsp_if rsp_ch ();
   agds_csr_if csr_ch ();

   assign req_ch.valid = req_valid;
   assign req_ch.meas_sample = req_meas;
   assign req_ch.ref_sample = req_ref;
   assign rsp_ch.ready = rsp_ready;
   assign csr_ch.valid = csr_valid;
   assign csr_ch.index = csr_index;
   assign csr_ch.data = csr_data;

   autorange_gain_divider_select_core #(.SAMPLES(WINDOW)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   always #2 clock = ~clock;

   sample_pair_type pending_pairs[$];
   range_report_type awaited_ranges[$];

   logic [SMP_W-1:0] low_thr = SIGNAL_LOW_RESET;
   logic [SMP_W-1:0] high_thr = SIGNAL_HIGH_RESET;
   logic [16:0] meas_total = '0;
   logic [16:0] ref_total = '0;
   int unsigned pairs_in_window = 0;
   logic [GAIN_W-1:0] gain_now = GAIN_RESET;
   logic [DIV_W-1:0] div_now = DIV_RESET;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int queued_items = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   sample_pair_type next_pair;
   range_report_type due;

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      end
   endtask

   task automatic accumulate_pair(input logic [SMP_W-1:0] meas, input logic [SMP_W-1:0] refs);
      range_report_type rpt;
      logic [GAIN_W-1:0] g;
      logic [DIV_W-1:0] d;
      meas_total = meas_total + meas;
      ref_total = ref_total + refs;
      pairs_in_window++;
      if (pairs_in_window == WINDOW) begin
         rpt.avg_meas = SMP_W'(meas_total / WINDOW);
         rpt.avg_ref = SMP_W'(ref_total / WINDOW);
         meas_total = '0;
         ref_total = '0;
         pairs_in_window = 0;
         g = gain_now;
         d = div_now;
         if (rpt.avg_meas < low_thr) begin
            if ((d == DIV_BOTTOM || d == DIV_TOP) && g == GAIN_TOP) begin
               g = GAIN_BOTTOM;
               d = (d == DIV_BOTTOM) ? DIV_BOTTOM + 1'b1 : DIV_TOP - 1'b1;
            end else if ((d == DIV_BOTTOM || d == DIV_TOP) && g == GAIN_BOTTOM) begin
               g = GAIN_BOTTOM + 1'b1;
            end else if (g < GAIN_TOP) begin
               g = g + 1'b1;
            end else if (d < DIV_TOP) begin
               d = d + 1'b1;
            end
         end else if (rpt.avg_meas > high_thr) begin
            if ((d == DIV_BOTTOM || d == DIV_TOP) && g == GAIN_TOP) begin
               g = GAIN_BOTTOM;
               d = (d == DIV_BOTTOM) ? DIV_BOTTOM + 1'b1 : DIV_TOP - 1'b1;
            end else if (d == DIV_BOTTOM && g == GAIN_BOTTOM) begin
               g = GAIN_BOTTOM;
            end else if (d == DIV_TOP && g == GAIN_BOTTOM) begin
               d = DIV_TOP - 1'b1;
            end else if (g > GAIN_BOTTOM && g <= GAIN_TOP) begin
               g = g - 1'b1;
            end else if (d > DIV_BOTTOM && d <= DIV_TOP) begin
               d = d - 1'b1;
            end
         end
         rpt.range_changed = (g != gain_now) || (d != div_now);
         rpt.gain_level = g;
         rpt.divider_level = d;
         gain_now = g;
         div_now = d;
         awaited_ranges.push_back(rpt);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SMP_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SIGNAL_LOW) begin
         low_thr = value;
      end else if (idx == CSR_SIGNAL_HIGH) begin
         high_thr = value;
      end
   endtask

   task automatic program_window(input logic [SMP_W-1:0] low, input logic [SMP_W-1:0] high);
      write_reg($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3, SMP_W'($urandom));
      write_reg(CSR_SIGNAL_LOW, low);
      write_reg(CSR_SIGNAL_HIGH, high);
   endtask

   function automatic logic [SMP_W-1:0] pick_threshold();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         return '0;
      end else if (roll < 20) begin
         return SMP_MAX;
      end
      return SMP_W'($urandom);
   endfunction

   task automatic push_constant_window(input logic [SMP_W-1:0] meas, input logic [SMP_W-1:0] refs);
      sample_pair_type pair;
      pair.meas_sample = meas;
      pair.ref_sample = refs;
      repeat (WINDOW) pending_pairs.push_back(pair);
      queued_items += WINDOW;
   endtask

   task automatic add_window();
      int roll;
      int count;
      logic [SMP_W-1:0] lo;
      logic [SMP_W-1:0] hi;
      logic [SMP_W-1:0] ref_lo;
      logic [SMP_W-1:0] ref_hi;
      sample_pair_type pair;
      roll = $urandom_range(99);
      count = WINDOW;
      lo = '0;
      hi = SMP_MAX;
      if (roll < 35) begin
         if (low_thr != '0) hi = low_thr - 1'b1;
      end else if (roll < 60) begin
         if (high_thr != SMP_MAX) lo = high_thr + 1'b1;
      end else if (roll < 72) begin
         lo = (low_thr < high_thr) ? low_thr : high_thr;
         hi = (low_thr < high_thr) ? high_thr : low_thr;
      end else if (roll < 78) begin
         lo = low_thr;
         hi = low_thr;
      end else if (roll < 84) begin
         lo = high_thr;
         hi = high_thr;
      end else if (roll >= 95) begin
         count = $urandom_range(WINDOW - 1, 1);
      end
      ref_lo = SMP_W'($urandom);
      ref_hi = SMP_W'($urandom_range(SMP_MAX, ref_lo));
      repeat (count) begin
         pair.meas_sample = SMP_W'($urandom_range(hi, lo));
         pair.ref_sample = SMP_W'($urandom_range(ref_hi, ref_lo));
         pending_pairs.push_back(pair);
      end
      queued_items += count;
   endtask

   task automatic settle_block();
      while (pending_pairs.size() != 0 || req_valid) @(posedge clock);
      while (awaited_ranges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            accumulate_pair(req_ch.meas_sample, req_ch.ref_sample);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_pair = pending_pairs.pop_front();
               req_valid <= 1'b1;
               req_meas <= next_pair.meas_sample;
               req_ref <= next_pair.ref_sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_ranges.size() == 0) begin
               report_mismatch("word with none expected, avg_meas", int'(rsp_ch.avg_meas), 0);
            end else begin
               due = awaited_ranges.pop_front();
               if (rsp_ch.avg_meas !== due.avg_meas)
                  report_mismatch("avg_meas", int'(rsp_ch.avg_meas), int'(due.avg_meas));
               if (rsp_ch.avg_ref !== due.avg_ref)
                  report_mismatch("avg_ref", int'(rsp_ch.avg_ref), int'(due.avg_ref));
               if (rsp_ch.gain_level !== due.gain_level)
                  report_mismatch("gain_level", int'(rsp_ch.gain_level), int'(due.gain_level));
               if (rsp_ch.divider_level !== due.divider_level)
                  report_mismatch("divider_level", int'(rsp_ch.divider_level),
                                  int'(due.divider_level));
               if (rsp_ch.range_changed !== due.range_changed)
                  report_mismatch("range_changed", int'(rsp_ch.range_changed),
                                  int'(due.range_changed));
            end
         end
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                   (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int mode;
      logic [SMP_W-1:0] low;
      logic [SMP_W-1:0] high;
      logic [SMP_W-1:0] swap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_constant_window(SMP_MAX, '0);
      push_constant_window('0, SMP_MAX);
      repeat (20) add_window();
      settle_block();

      program_window('0, SMP_MAX);
      send_idle_pct = 72;
      stall_pct = 0;
      repeat (10) add_window();
      settle_block();

      program_window(SMP_MAX, '0);
      send_idle_pct = 0;
      stall_pct = 72;
      repeat (12) add_window();
      settle_block();

      program_window(pick_threshold(), pick_threshold());
      send_idle_pct = 28;
      stall_pct = 28;
      repeat (16) add_window();
      settle_block();

      program_window(SIGNAL_LOW_RESET, SIGNAL_HIGH_RESET);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_asked++;
      repeat (20) add_window();
      settle_block();

      while (queued_items < ITEM_TARGET) begin
         low = pick_threshold();
         high = pick_threshold();
         if ($urandom_range(3) != 0 && low > high) begin
            swap = low;
            low = high;
            high = swap;
         end
         program_window(low, high);
         mode = $urandom_range(3);
         send_idle_pct = (mode == 1) ? 72 : (mode == 3) ? 28 : 0;
         stall_pct = (mode == 2) ? 72 : (mode == 3) ? 28 : 0;
         repeat ($urandom_range(24, 8)) begin
            if (queued_items < ITEM_TARGET) add_window();
         end
         settle_block();
      end

      if (awaited_ranges.size() != 0) begin
         report_mismatch("words never delivered", 0, awaited_ranges.size());
      end
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
